>>> src/three_stacks_one_memory_top_defines.svh
// Assertion macros for the three-stack block checker.
// Used by tsom_checker.sv; no other dependencies.
`ifndef THREE_STACKS_ONE_MEMORY_TOP_DEFINES_SVH
`define THREE_STACKS_ONE_MEMORY_TOP_DEFINES_SVH

// same-cycle implication
`define TSOM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSOM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/tsom_pkg.sv
// Package for the three-stack block: codes, widths, FSM state and
// controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsom_pkg;

  localparam int NUM_STACKS = 3;
  localparam int SEL_W      = 2;
  localparam int ACT_W      = 2;
  localparam int ST_W       = 2;
  localparam int PAYLOAD_W  = 32;

  localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TOP  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch_item;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/tsom_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tsom_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/tsom_ctrl.sv
// Controller FSM for the three-stack block: accept, execute, deliver.
// Depends on tsom_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsom_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tsom_pkg::dp_status_t dp_status,
  output tsom_pkg::ctrl_cmd_t      cmd
);

  tsom_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsom_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsom_pkg::S_IDLE: begin
        if (in_valid) state_nxt = tsom_pkg::S_EXEC;
      end
      tsom_pkg::S_EXEC: begin
        state_nxt = tsom_pkg::S_DONE;
      end
      tsom_pkg::S_DONE: begin
        if (!dp_status.out_busy) state_nxt = tsom_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tsom_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      tsom_pkg::S_IDLE: begin
        in_stall       = 1'b0;
        cmd.latch_item = in_valid;
      end
      tsom_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      tsom_pkg::S_DONE: begin
        cmd.load_out = !dp_status.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/tsom_datapath.sv
// Datapath for the three-stack block: item register, fill levels,
// shared stack memory and output register. Depends on tsom_pkg, tsom_ram.
`timescale 1ns / 1ps
`default_nettype none

module tsom_datapath #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tsom_pkg::ctrl_cmd_t                 cmd,
  output tsom_pkg::dp_status_t                     dp_status,
  input  wire logic        [tsom_pkg::ACT_W-1:0]   in_action,
  input  wire logic        [tsom_pkg::SEL_W-1:0]   in_stack_select,
  input  wire logic signed [tsom_pkg::PAYLOAD_W-1:0] in_push_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [tsom_pkg::PAYLOAD_W-1:0] out_read_value,
  output logic                                     out_now_empty,
  output logic             [tsom_pkg::ST_W-1:0]    out_status
);

  localparam int MEM_DEPTH = tsom_pkg::NUM_STACKS * STACK_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int LVL_W     = $clog2(STACK_DEPTH + 1);
  localparam int EXT_W     = DATA_WIDTH + tsom_pkg::PAYLOAD_W;

  // item register
  logic [tsom_pkg::ACT_W-1:0]     act_r;
  logic [tsom_pkg::SEL_W-1:0]     sel_r;
  logic [tsom_pkg::PAYLOAD_W-1:0] val_r;

  logic [LVL_W-1:0] lvl_r [tsom_pkg::NUM_STACKS];

  // per-item result held between execute and delivery
  logic                     top_ok_r;
  logic                     res_empty_r;
  logic [tsom_pkg::ST_W-1:0] res_status_r;

  logic                                out_valid_r;
  logic [tsom_pkg::PAYLOAD_W-1:0]      out_read_value_r;
  logic                                out_now_empty_r;
  logic [tsom_pkg::ST_W-1:0]           out_status_r;

  logic                      sel_ok;
  logic [LVL_W-1:0]          lvl_cur;
  logic [LVL_W-1:0]          lvl_new;
  logic [LVL_W-1:0]          slot;
  logic                      is_full, is_empty;
  logic                      is_push, is_pop, is_top;
  logic                      push_ok, pop_ok, top_ok;
  logic [tsom_pkg::ST_W-1:0] status_c;
  logic [ADDR_W-1:0]         addr;
  logic [EXT_W-1:0]          wr_ext;
  logic [DATA_WIDTH-1:0]     rd_data;
  logic [EXT_W-1:0]          rd_ext;

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      act_r <= in_action;
      sel_r <= in_stack_select;
      val_r <= in_push_value;
    end
  end

  assign sel_ok  = (sel_r < tsom_pkg::SEL_W'(tsom_pkg::NUM_STACKS));
  assign is_push = (act_r == tsom_pkg::ACT_PUSH);
  assign is_pop  = (act_r == tsom_pkg::ACT_POP);
  assign is_top  = (act_r == tsom_pkg::ACT_TOP);

  always_comb begin
    lvl_cur = '0;
    for (int i = 0; i < tsom_pkg::NUM_STACKS; i++) begin
      if (sel_r == tsom_pkg::SEL_W'(i)) lvl_cur = lvl_r[i];
    end
  end

  // unused select behaves as a zero-capacity stack
  assign is_empty = (lvl_cur == '0);
  assign is_full  = !sel_ok || (lvl_cur == LVL_W'(STACK_DEPTH));
  assign push_ok  = is_push && !is_full;
  assign pop_ok   = is_pop && !is_empty;
  assign top_ok   = is_top && !is_empty;

  always_comb begin
    status_c = tsom_pkg::ST_OK;
    if (is_push && is_full) begin
      status_c = tsom_pkg::ST_OVERFLOW;
    end else if ((is_pop || is_top) && is_empty) begin
      status_c = tsom_pkg::ST_UNDERFLOW;
    end
  end

  always_comb begin
    lvl_new = lvl_cur;
    if (push_ok) begin
      lvl_new = lvl_cur + LVL_W'(1);
    end else if (pop_ok) begin
      lvl_new = lvl_cur - LVL_W'(1);
    end
  end

  assign slot = is_push ? lvl_cur : (lvl_cur - LVL_W'(1));
  assign addr = ADDR_W'(sel_r) * ADDR_W'(STACK_DEPTH) + ADDR_W'(slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tsom_pkg::NUM_STACKS; i++) begin
        lvl_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      for (int i = 0; i < tsom_pkg::NUM_STACKS; i++) begin
        if (sel_r == tsom_pkg::SEL_W'(i)) lvl_r[i] <= lvl_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      top_ok_r     <= top_ok;
      res_empty_r  <= (lvl_new == '0);
      res_status_r <= status_c;
    end
  end

  assign wr_ext = {{DATA_WIDTH{val_r[tsom_pkg::PAYLOAD_W-1]}}, val_r};

  tsom_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && push_ok),
    .re    (cmd.exec && top_ok),
    .addr  (addr),
    .wdata (wr_ext[DATA_WIDTH-1:0]),
    .rdata (rd_data)
  );

  assign rd_ext = {{tsom_pkg::PAYLOAD_W{1'b0}}, rd_data};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_value_r <= top_ok_r ? rd_ext[tsom_pkg::PAYLOAD_W-1:0] : '0;
      out_now_empty_r  <= res_empty_r;
      out_status_r     <= res_status_r;
    end
  end

  assign dp_status.out_busy = out_valid_r && out_stall;

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_now_empty  = out_now_empty_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

>>> src/three_stacks_one_memory_top.sv
// Top level of the three-stack block: controller plus datapath.
// Depends on tsom_pkg, tsom_ctrl, tsom_datapath, tsom_ram.
//
//   channel | direction | handshake            | fields
//   in_     | input     | in_valid / in_stall  | action, stack_select, push_value
//   out_    | output    | out_valid / out_stall| read_value, now_empty, status
//
// Each item passes these steps from accept to result in the output register:
// accept, execute (fill level update and at most one memory access), deliver.
// The memory's registered read sets the deliver step.
// Reset clears the fill levels and handshake state; memory content is not reset.
// A result held by out_stall blocks delivery of the next one; one more item
// may be accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module three_stacks_one_memory_top #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  in_action,
  input  wire logic        [1:0]  in_stack_select,
  input  wire logic signed [31:0] in_push_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [31:0] out_read_value,
  output logic                    out_now_empty,
  output logic             [1:0]  out_status
);

  tsom_pkg::ctrl_cmd_t  cmd;
  tsom_pkg::dp_status_t dp_status;

  tsom_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  tsom_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .dp_status       (dp_status),
    .in_action       (in_action),
    .in_stack_select (in_stack_select),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_now_empty   (out_now_empty),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

>>> src/tsom_checker.sv
// Port-level assertions for the three-stack block, bound to the top level.
// Depends on tsom_pkg and three_stacks_one_memory_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "three_stacks_one_memory_top_defines.svh"

module tsom_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_read_value,
  input wire logic        out_now_empty,
  input wire logic [1:0]  out_status
);

  `TSOM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_value) && $stable(out_status) && $stable(out_now_empty), "stalled result changed")
  `TSOM_ASSERT_NOW(a_status_code, out_valid, out_status <= tsom_pkg::ST_UNDERFLOW, "undefined status code")
  `TSOM_ASSERT_NOW(a_reject_zero, out_valid && out_status != tsom_pkg::ST_OK, out_read_value == '0, "rejected item returned data")
  `TSOM_ASSERT_NOW(a_underflow_empty, out_valid && out_status == tsom_pkg::ST_UNDERFLOW, out_now_empty, "underflow on non-empty stack")
  `TSOM_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second item taken while busy")

endmodule

bind three_stacks_one_memory_top tsom_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_value (out_read_value),
  .out_now_empty  (out_now_empty),
  .out_status     (out_status)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for three_stacks_one_memory_top: directed and random push, pop,
// top and unused-code items, checked against a stack predictor kept inside the bench.
// Depends on tsom_pkg and the RTL of the block.
module tb;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int LATENCY     = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 80;

  localparam logic [tsom_pkg::ACT_W-1:0] ACT_NONE = 2'd3;
  localparam logic [tsom_pkg::SEL_W-1:0] SEL_NONE = 2'd3;

  typedef struct packed {
    logic signed [31:0]           read_value;
    logic                         now_empty;
    logic [tsom_pkg::ST_W-1:0]    status;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [tsom_pkg::ACT_W-1:0] in_action;
  logic [tsom_pkg::SEL_W-1:0] in_stack_select;
  logic signed [31:0] in_push_value;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_read_value;
  logic out_now_empty;
  logic [tsom_pkg::ST_W-1:0] out_status;

  logic [DATA_WIDTH-1:0] shadow_mem [tsom_pkg::NUM_STACKS*STACK_DEPTH];
  int shadow_level [tsom_pkg::NUM_STACKS];
  stack_result_t pending_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  three_stacks_one_memory_top #(
    .STACK_DEPTH(STACK_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_stack_select(in_stack_select),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_now_empty  (out_now_empty),
    .out_status     (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic stack_result_t apply_stack_op(input logic [tsom_pkg::ACT_W-1:0] act,
                                                   input logic [tsom_pkg::SEL_W-1:0] sel,
                                                   input logic signed [31:0] val);
    stack_result_t r;
    int lvl;
    int base;
    r.read_value = '0;
    r.status = tsom_pkg::ST_OK;
    r.now_empty = 1'b1;
    if (sel < tsom_pkg::NUM_STACKS) begin
      lvl = shadow_level[sel];
      base = sel * STACK_DEPTH;
      case (act)
        tsom_pkg::ACT_PUSH: begin
          if (lvl >= STACK_DEPTH) begin
            r.status = tsom_pkg::ST_OVERFLOW;
          end else begin
            shadow_mem[base + lvl] = val;
            lvl++;
          end
        end
        tsom_pkg::ACT_POP: begin
          if (lvl == 0) r.status = tsom_pkg::ST_UNDERFLOW;
          else lvl--;
        end
        tsom_pkg::ACT_TOP: begin
          if (lvl == 0) r.status = tsom_pkg::ST_UNDERFLOW;
          else r.read_value = shadow_mem[base + lvl - 1];
        end
        default: ;
      endcase
      shadow_level[sel] = lvl;
      r.now_empty = (lvl == 0);
    end else begin
      if (act == tsom_pkg::ACT_PUSH) r.status = tsom_pkg::ST_OVERFLOW;
      else if (act == tsom_pkg::ACT_POP || act == tsom_pkg::ACT_TOP)
        r.status = tsom_pkg::ST_UNDERFLOW;
    end
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%s mismatch: expected %0h, got %0h", what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("result with no item pending");
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.read_value, out_read_value);
        check_field("now_empty", 32'(want.now_empty), 32'(out_now_empty));
        check_field("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [tsom_pkg::ACT_W-1:0] act,
                           input logic [tsom_pkg::SEL_W-1:0] sel,
                           input logic signed [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_stack_select <= sel;
    in_push_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_stack_op(act, sel, val));
    @(negedge clk);
  endtask

  task automatic wait_for_results;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic send_random_item(input int push_pct);
    logic [tsom_pkg::ACT_W-1:0] act;
    logic [tsom_pkg::SEL_W-1:0] sel;
    logic signed [31:0] val;
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) act = 2'($urandom_range(3));
    else if (roll < 4 + push_pct * 96 / 100) act = tsom_pkg::ACT_PUSH;
    else act = $urandom_range(1) ? tsom_pkg::ACT_POP : tsom_pkg::ACT_TOP;
    sel = ($urandom_range(19) == 0) ? SEL_NONE : 2'($urandom_range(tsom_pkg::NUM_STACKS - 1));
    case ($urandom_range(7))
      0: val = 32'sh8000_0000;
      1: val = 32'sh7fff_ffff;
      2: val = '0;
      3: val = -32'sd1;
      default: val = $urandom;
    endcase
    send_item(act, sel, val);
  endtask

  task automatic test_empty_stacks;
    send_item(tsom_pkg::ACT_POP, 2'd0, 32'sd5);
    send_item(tsom_pkg::ACT_TOP, 2'd2, -32'sd1);
    send_item(ACT_NONE, 2'd0, 32'sh7fff_ffff);
    wait_for_results();
  endtask

  task automatic test_unused_codes;
    send_item(tsom_pkg::ACT_PUSH, SEL_NONE, 32'sh1234_5678);
    send_item(tsom_pkg::ACT_POP, SEL_NONE, '0);
    send_item(tsom_pkg::ACT_TOP, SEL_NONE, '0);
    send_item(ACT_NONE, SEL_NONE, -32'sd1);
    wait_for_results();
  endtask

  task automatic test_fill_and_overflow;
    logic signed [31:0] val;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      case (i)
        0: val = 32'sh8000_0000;
        1: val = 32'sh7fff_ffff;
        2: val = '0;
        3: val = -32'sd1;
        default: val = $urandom;
      endcase
      send_item(tsom_pkg::ACT_PUSH, 2'd1, val);
    end
    send_item(tsom_pkg::ACT_PUSH, 2'd1, 32'sh5555_aaaa);
    send_item(tsom_pkg::ACT_TOP, 2'd1, '0);
    send_item(tsom_pkg::ACT_POP, 2'd1, '0);
    send_item(tsom_pkg::ACT_TOP, 2'd1, '0);
    wait_for_results();
  endtask

  task automatic test_random_phase(input int n_items, input int send_pct, input int recv_pct);
    int push_pct;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    push_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      send_random_item(push_pct);
    end
    wait_for_results();
  endtask

  task automatic test_random_traffic;
    test_random_phase(100, 0, 0);
    test_random_phase(100, 67, 0);
    test_random_phase(100, 0, 67);
    test_random_phase(100, 29, 29);
  endtask

  // sender keeps offering while the receiver holds off, so the input backs up
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (12) send_random_item(50);
    wait_for_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = tsom_pkg::ACT_PUSH;
    in_stack_select = '0;
    in_push_value = '0;
    for (int s = 0; s < tsom_pkg::NUM_STACKS; s++) shadow_level[s] = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_stacks();
    test_unused_codes();
    test_fill_and_overflow();
    test_random_traffic();
    test_backpressure();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
